[rtl/core/assert_macros.svh]
// assertion macros used by the rtl of the interpolator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QEI_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("assertion failed: label");
`define QEI_ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition: label");
`else
`define QEI_ASSERT(label, clk, rstn, prop)
`define QEI_ASSERT_NEVER(label, clk, rstn, expr)
`endif
`endif

[rtl/core/qei_pkg.sv]
// types and constants of the quadratic ease interpolator
package qei_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned RATIO_W = 17;
  localparam int unsigned OP_W    = 3;

  localparam logic [RATIO_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [RATIO_W-1:0] HALF_Q16 = 17'd32768;

  typedef enum logic [OP_W-1:0] {
    OP_LINEAR = 3'd0,
    OP_IN     = 3'd1,
    OP_OUT    = 3'd2,
    OP_IN_OUT = 3'd3,
    OP_OUT_IN = 3'd4
  } ease_op_t;

  typedef enum logic [1:0] {
    SHAPE_LIN = 2'd0,
    SHAPE_IN  = 2'd1,
    SHAPE_OUT = 2'd2
  } shape_t;

endpackage

[rtl/core/quadratic_ease_interpolator.sv]
// quadratic ease interpolator: start + p*(end-start) in q16.16, p shaped by the ease mode
// pipeline: four register stages, out_tvalid is the valid bit of the fourth stage
// throughput: one request per cycle while out_tready does not stall; the two multipliers sit in separate stages
// bubbles close up behind a stalled result; input stalls only when all four stages are full
// reset: synchronous active-low rst_n clears every stage valid bit; data registers hold
`include "assert_macros.svh"

module quadratic_ease_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // start_value[31:0], end_value[63:32], ratio[80:64], zero pad
  input  logic [2:0]  in_tuser,   // operation[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // eased_value[31:0]
);

  localparam int unsigned VW = qei_pkg::VAL_W;
  localparam int unsigned RW = qei_pkg::RATIO_W;

  // per-stage ready
  logic rdy1, rdy2, rdy3, rdy4;
  logic v1_r, v2_r, v3_r, v4_r;

  assign rdy4 = !v4_r || out_tready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_tready = rdy1;

  // stage 1: saturate ratio, midpoint, pick segment
  logic signed [VW-1:0] s_in, e_in;
  logic [RW-1:0]        r_sat;
  logic signed [VW:0]   sum_se;
  logic signed [VW-1:0] mid;
  logic [RW:0]          dbl;
  logic [RW:0]          dbl_hi;
  logic [RW-1:0]        x_lo, x_hi;
  logic                 upper;

  logic signed [VW-1:0] a1_nxt, b1_nxt, a1_r, b1_r;
  logic [RW-1:0]        x1_nxt, x1_r;
  qei_pkg::shape_t      sh1_nxt, sh1_r;

  always_comb begin
    s_in   = $signed(in_tdata[31:0]);
    e_in   = $signed(in_tdata[63:32]);
    r_sat  = (in_tdata[80:64] > qei_pkg::ONE_Q16) ? qei_pkg::ONE_Q16 : in_tdata[80:64];
    sum_se = {s_in[VW-1], s_in} + {e_in[VW-1], e_in};
    mid    = sum_se[VW:1];
    dbl    = {r_sat, 1'b0};
    dbl_hi = dbl - {1'b0, qei_pkg::ONE_Q16};
    x_lo   = dbl[RW-1:0];
    x_hi   = dbl_hi[RW-1:0];
    upper  = (r_sat >= qei_pkg::HALF_Q16);
  end

  always_comb begin
    a1_nxt  = s_in;
    b1_nxt  = e_in;
    x1_nxt  = r_sat;
    sh1_nxt = qei_pkg::SHAPE_LIN;
    case (qei_pkg::ease_op_t'(in_tuser))
      qei_pkg::OP_IN:  sh1_nxt = qei_pkg::SHAPE_IN;
      qei_pkg::OP_OUT: sh1_nxt = qei_pkg::SHAPE_OUT;
      qei_pkg::OP_IN_OUT: begin
        if (upper) begin
          a1_nxt  = mid;
          x1_nxt  = x_hi;
          sh1_nxt = qei_pkg::SHAPE_OUT;
        end else begin
          b1_nxt  = mid;
          x1_nxt  = x_lo;
          sh1_nxt = qei_pkg::SHAPE_IN;
        end
      end
      qei_pkg::OP_OUT_IN: begin
        if (upper) begin
          a1_nxt  = mid;
          x1_nxt  = x_hi;
          sh1_nxt = qei_pkg::SHAPE_IN;
        end else begin
          b1_nxt  = mid;
          x1_nxt  = x_lo;
          sh1_nxt = qei_pkg::SHAPE_OUT;
        end
      end
      default: sh1_nxt = qei_pkg::SHAPE_LIN;
    endcase
  end

  // stage 2: square and difference
  logic [RW-1:0]        q2;
  logic [2*RW-1:0]      sq_full;
  logic [RW-1:0]        sq2_nxt, sq2_r;
  logic signed [VW:0]   d2_nxt, d2_r;
  logic signed [VW-1:0] a2_r;
  logic [RW-1:0]        x2_r;
  qei_pkg::shape_t      sh2_r;

  always_comb begin
    q2      = (sh1_r == qei_pkg::SHAPE_OUT) ? (qei_pkg::ONE_Q16 - x1_r) : x1_r;
    sq_full = q2 * q2;
    sq2_nxt = sq_full[RW+15:16];
    d2_nxt  = {b1_r[VW-1], b1_r} - {a1_r[VW-1], a1_r};
  end

  // stage 3: scale difference by shaped ratio
  logic [RW-1:0]           p3;
  logic signed [VW+RW+1:0] prod3_nxt, prod3_r;
  logic signed [VW-1:0]    a3_r;

  always_comb begin
    case (sh2_r)
      qei_pkg::SHAPE_IN:  p3 = sq2_r;
      qei_pkg::SHAPE_OUT: p3 = qei_pkg::ONE_Q16 - sq2_r;
      default:            p3 = x2_r;
    endcase
    prod3_nxt = d2_r * $signed({1'b0, p3});
  end

  // stage 4: add back the start
  logic signed [VW+RW-15:0] acc4;
  logic [VW-1:0]            out_nxt, out_r;

  always_comb begin
    acc4    = {{(RW-14){a3_r[VW-1]}}, a3_r} + prod3_r[VW+RW+1:16];
    out_nxt = acc4[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      a1_r  <= a1_nxt;
      b1_r  <= b1_nxt;
      x1_r  <= x1_nxt;
      sh1_r <= sh1_nxt;
    end
    if (rdy2) begin
      sq2_r <= sq2_nxt;
      d2_r  <= d2_nxt;
      a2_r  <= a1_r;
      x2_r  <= x1_r;
      sh2_r <= sh1_r;
    end
    if (rdy3) begin
      prod3_r <= prod3_nxt;
      a3_r    <= a2_r;
    end
    if (rdy4) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = out_r;

  `QEI_ASSERT(a_full_when_blocked, clk, rst_n, !in_tready |-> (v1_r && v2_r && v3_r && v4_r))
  `QEI_ASSERT_NEVER(a_ratio_range, clk, rst_n, v1_r && (x1_r > qei_pkg::ONE_Q16))
  `QEI_ASSERT_NEVER(a_square_range, clk, rst_n, v2_r && (sq2_r > qei_pkg::ONE_Q16))
  `QEI_ASSERT(a_stage_moves, clk, rst_n, (v3_r && rdy4) |=> v4_r)

endmodule
